FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the allocator modules; they
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every edge out of reset
`define CBA_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define CBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define CBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CBA_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define CBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/cba_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous block allocator package
// Result codes, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cba_pkg;

   // field widths of one item
   localparam int OWNER_W = 8;
   localparam int START_W = 5;
   localparam int COUNT_W = 6;
   localparam int INDEX_W = 4;

   // map entry value of a free block ('.')
   localparam logic [OWNER_W-1:0] FREE_MARK = 8'd46;

   typedef enum logic [1:0] {
      RSP_GRANTED  = 2'd0,
      RSP_RANGE    = 2'd1,
      RSP_OCCUPIED = 2'd2,
      RSP_FULL     = 2'd3
   } rsp_code_type;

   // controller to datapath
   typedef struct packed {
      logic         load;     // capture request fields
      logic         read;     // read map entry at pointer
      logic         step;     // advance pointer, count down remaining
      logic         rewind;   // pointer back to start of extent
      logic         write;    // mark map entry at pointer with owner
      logic         emit;     // load result into output register
      rsp_code_type code;     // result code for emit
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_bad;   // extent runs past end of map
      logic remain_zero; // no blocks left in this pass
      logic remain_last; // one block left in this pass
      logic occupied;    // last map entry read is owned
      logic dir_full;    // no free directory slot
      logic out_free;    // output register can take a result
   } stat_type;

endpackage

FILE: hdl/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous block allocator
// Grants contiguous extents of a block map to owner ids and records them
// in a directory of extents.
// ----------------------------------------------------------------------------
// Usage:
//   A request item on req_ (owner id, start block, block count) yields one
//   result item on rsp_ (status, directory slot). Status is out of range,
//   blocks occupied, directory full or granted, tested in that order.
//   One request is worked at a time. The scan reads each block from the
//   registered map memory and then tests it; the fill writes one block a
//   cycle. The next request is taken in the cycle after its predecessor's
//   result is loaded.
//   The result sits in an output register; a new request is taken while it
//   waits, and that request holds at its end until the register is free.
//   Reset frees every map block and empties the directory at once; the
//   block is ready in the cycle after reset falls.
// ----------------------------------------------------------------------------
module contiguous_block_allocator #(
   parameter int BLOCKS      = 32,
   parameter int DIR_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // owner_id[7:0], start_block[12:8], block_count[18:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // status[1:0], entry_index[5:2]
);

   cba_pkg::cmd_type               cmd;
   cba_pkg::stat_type              stat;
   cba_pkg::rsp_code_type          rsp_status;
   logic [cba_pkg::INDEX_W-1:0]    rsp_entry_index;

   cba_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cba_datapath #(
      .BLOCKS      (BLOCKS),
      .DIR_ENTRIES (DIR_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .owner_id        (req_tdata[7:0]),
      .start_block     (req_tdata[12:8]),
      .block_count     (req_tdata[18:13]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index)
   );

   // pack result fields
   assign rsp_tdata = {2'b00, rsp_entry_index, rsp_status};

endmodule

FILE: hdl/cba_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Request registers, extent pointer and down-counter, block map memory with
// per-entry valid bits, directory fill count and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cba_datapath #(
   parameter int BLOCKS      = 32,
   parameter int DIR_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cba_pkg::OWNER_W-1:0]     owner_id,
   input  logic [cba_pkg::START_W-1:0]     start_block,
   input  logic [cba_pkg::COUNT_W-1:0]     block_count,
   input  cba_pkg::cmd_type                cmd,
   output cba_pkg::stat_type               stat,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output cba_pkg::rsp_code_type           rsp_status,
   output logic [cba_pkg::INDEX_W-1:0]     rsp_entry_index
);

   localparam int AW    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_W = $clog2(DIR_ENTRIES + 1);
   localparam int SUM_W = ($clog2(BLOCKS + 1) > 7) ? $clog2(BLOCKS + 1) : 7;

   logic [cba_pkg::OWNER_W-1:0] owner_ff, owner_in;
   logic [cba_pkg::START_W-1:0] start_ff, start_in;
   logic [cba_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [cba_pkg::COUNT_W-1:0] remain_ff, remain_in;
   logic [CNT_W-1:0]            extents_ff, extents_in;
   logic [BLOCKS-1:0]           valid_ff, valid_in;
   logic [cba_pkg::OWNER_W-1:0] blk_mem [BLOCKS];
   logic [cba_pkg::OWNER_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   cba_pkg::rsp_code_type       rsp_status_ff, rsp_status_in;
   logic [cba_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                        grant;

   assign grant = cmd.emit && (cmd.code == cba_pkg::RSP_GRANTED);

   // request fields, pointer and remaining count
   always_comb begin
      owner_in  = owner_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      remain_in = remain_ff;
      if (cmd.load) begin
         owner_in  = owner_id;
         start_in  = start_block;
         count_in  = block_count;
         ptr_in    = AW'(start_block);
         remain_in = block_count;
      end else if (cmd.rewind) begin
         ptr_in    = AW'(start_ff);
         remain_in = count_ff;
      end else if (cmd.step) begin
         ptr_in    = ptr_ff + AW'(1);
         remain_in = remain_ff - cba_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      owner_ff  <= owner_in;
      start_ff  <= start_in;
      count_ff  <= count_in;
      ptr_ff    <= ptr_in;
      remain_ff <= remain_in;
   end

   // valid bits: an entry never written reads as free
   always_comb begin
      valid_in = valid_ff;
      if (cmd.write) begin
         valid_in[ptr_ff] = 1'b1;
      end
   end

   // block map memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         blk_mem[ptr_ff] <= owner_ff;
      end
      if (cmd.read) begin
         rd_data_ff  <= blk_mem[ptr_ff];
         rd_valid_ff <= valid_ff[ptr_ff];
      end
   end

   // directory fill count and result register
   always_comb begin
      extents_in    = extents_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.code;
         rsp_index_in  = '0;
         if (grant) begin
            rsp_index_in = cba_pkg::INDEX_W'(extents_ff);
            extents_in   = extents_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         extents_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         extents_ff   <= extents_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // status to controller
   always_comb begin
      stat.range_bad   = (SUM_W'(start_ff) + SUM_W'(count_ff)) > SUM_W'(BLOCKS);
      stat.remain_zero = (remain_ff == '0);
      stat.remain_last = (remain_ff == cba_pkg::COUNT_W'(1));
      stat.occupied    = rd_valid_ff && (rd_data_ff != cba_pkg::FREE_MARK);
      stat.dir_full    = (extents_ff == CNT_W'(DIR_ENTRIES));
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;

   `CBA_ASSERT_ALWAYS(a_count_bound, clock, reset, extents_ff <= CNT_W'(DIR_ENTRIES))
   `CBA_ASSERT_IMPLY(a_no_grant_full, clock, reset, grant, !stat.dir_full)
   `CBA_ASSERT_IMPLY(a_write_in_map, clock, reset, cmd.write, ptr_ff < BLOCKS)

endmodule

FILE: hdl/cba_controller.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one request: range test, occupancy scan reading then testing
// each block, directory test, fill one block per cycle, then result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cba_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cba_pkg::stat_type     stat,
   output cba_pkg::cmd_type      cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RANGE  = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_TEST   = 7'b0001000,
      ST_FINISH = 7'b0010000,
      ST_FILL   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   cba_pkg::rsp_code_type code_ff, code_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.code   = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (stat.range_bad) begin
               code_in  = cba_pkg::RSP_RANGE;
               state_in = ST_DONE;
            end else if (stat.remain_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (stat.occupied) begin
               code_in  = cba_pkg::RSP_OCCUPIED;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = stat.remain_last ? ST_FINISH : ST_READ;
            end
         end
         ST_FINISH: begin
            if (stat.dir_full) begin
               code_in  = cba_pkg::RSP_FULL;
               state_in = ST_DONE;
            end else begin
               cmd.rewind = 1'b1;
               state_in   = ST_FILL;
            end
         end
         ST_FILL: begin
            if (stat.remain_zero) begin
               code_in  = cba_pkg::RSP_GRANTED;
               state_in = ST_DONE;
            end else begin
               cmd.write = 1'b1;
               cmd.step  = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   `CBA_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, stat.out_free)
   `CBA_ASSERT_NEXT(a_accept_range, clock, reset, req_tvalid && req_tready, state_ff == ST_RANGE)
   `CBA_ASSERT_IMPLY(a_write_fill, clock, reset, cmd.write, state_ff == ST_FILL)

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Contiguous block allocator testbench
// Streams allocation requests into the allocator and checks every reply
// against a model of the block map and the extent directory. A short
// directed run covers range limits, clashes, zero-length extents and the
// free-marker owner. Random requests follow under three idling patterns,
// with one long reply stall that backs the allocator up onto its input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_BLOCKS       = 32;
   localparam int DIR_SLOTS        = 16;
   localparam int RANDOM_PER_PHASE = 347;
   localparam int HOLD_CYCLES      = 400;
   localparam int DRAIN_CYCLES     = 120;
   localparam int CYCLE_LIMIT      = 600000;

   typedef struct {
      cba_pkg::rsp_code_type       status;
      logic [cba_pkg::INDEX_W-1:0] slot;
   } reply_type;

   // map and directory model plus the replies still owed by the allocator
   class extent_scoreboard;
      logic [cba_pkg::OWNER_W-1:0] block_map [MAP_BLOCKS];
      int unsigned                 slots_used;
      reply_type                   pending_replies [$];
      int unsigned                 errors;
      int unsigned                 code_seen [4];

      function new();
         foreach (block_map[i]) block_map[i] = cba_pkg::FREE_MARK;
         foreach (code_seen[i]) code_seen[i] = 0;
         slots_used = 0;
         errors     = 0;
      endfunction

      // range first, then occupancy, then directory space
      function void claim_extent(logic [cba_pkg::OWNER_W-1:0] owner,
                                 logic [cba_pkg::START_W-1:0] first,
                                 logic [cba_pkg::COUNT_W-1:0] count);
         reply_type   r;
         int unsigned stop;
         r.status = cba_pkg::RSP_GRANTED;
         r.slot   = '0;
         stop     = 32'(first) + 32'(count);
         if (stop > MAP_BLOCKS) begin
            r.status = cba_pkg::RSP_RANGE;
         end else begin
            for (int i = int'(first); i < stop; i++)
               if (block_map[i] != cba_pkg::FREE_MARK) r.status = cba_pkg::RSP_OCCUPIED;
            if (r.status == cba_pkg::RSP_GRANTED && slots_used >= DIR_SLOTS)
               r.status = cba_pkg::RSP_FULL;
         end
         if (r.status == cba_pkg::RSP_GRANTED) begin
            r.slot = slots_used[cba_pkg::INDEX_W-1:0];
            // an owner equal to the free marker leaves the blocks reading free
            for (int i = int'(first); i < stop; i++) block_map[i] = owner;
            slots_used++;
         end
         code_seen[r.status]++;
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [7:0] data);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t: reply with none outstanding, status %0d slot %0d",
                     $time, data[1:0], data[5:2]);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (data[1:0] !== want.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, data[1:0]);
            errors++;
         end
         if (data[5:2] !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d got %0d",
                     $time, want.slot, data[5:2]);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // owner_id[7:0], start_block[12:8], block_count[18:13]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // status[1:0], entry_index[5:2]

   extent_scoreboard alloc_board = new();
   int unsigned      send_idle_pct = 27;
   int unsigned      take_idle_pct = 58;
   bit               hold_wanted   = 1'b0;
   int unsigned      cycle_count   = 0;

   always #6 clock = ~clock;

   contiguous_block_allocator #(
      .BLOCKS      (MAP_BLOCKS),
      .DIR_ENTRIES (DIR_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // handshake monitor: requests feed the model, replies are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            alloc_board.claim_extent(req_tdata[7:0], req_tdata[12:8], req_tdata[18:13]);
         if (rsp_tvalid && rsp_tready) alloc_board.check_reply(rsp_tdata);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run stuck after %0d cycles", $time, CYCLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // reply side: random back-pressure, or a long hold when asked for
   initial begin : reply_sink
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_left   = HOLD_CYCLES;
            hold_wanted = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   // offer one request, holding it until the allocator takes it
   task automatic offer_request(logic [cba_pkg::OWNER_W-1:0] owner,
                                logic [cba_pkg::START_W-1:0] first,
                                logic [cba_pkg::COUNT_W-1:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, count, first, owner};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // random request, weighted towards short extents and the map end
   task automatic offer_random();
      logic [cba_pkg::OWNER_W-1:0] owner;
      logic [cba_pkg::START_W-1:0] first;
      logic [cba_pkg::COUNT_W-1:0] count;
      int unsigned                 pick;
      int unsigned                 reach;
      owner = ($urandom_range(7) == 0) ? cba_pkg::FREE_MARK : cba_pkg::OWNER_W'($urandom);
      first = cba_pkg::START_W'($urandom_range(MAP_BLOCKS - 1));
      pick  = $urandom_range(99);
      if (pick < 40) begin
         count = cba_pkg::COUNT_W'($urandom_range(4));
      end else if (pick < 70) begin
         count = cba_pkg::COUNT_W'($urandom_range(12, 5));
      end else if (pick < 90) begin
         count = cba_pkg::COUNT_W'($urandom_range(MAP_BLOCKS, 13));
      end else begin
         // end exactly on the map boundary or one past it
         reach = MAP_BLOCKS - 32'(first) + $urandom_range(1);
         if (reach > MAP_BLOCKS) reach = MAP_BLOCKS;
         count = cba_pkg::COUNT_W'(reach);
      end
      offer_request(owner, first, count);
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: whole map to the free-marker owner, blocks stay free
      offer_request(cba_pkg::FREE_MARK, 5'd0, 6'd32);
      // past the end, widest and narrowest overshoot
      offer_request(8'd0, 5'd31, 6'd32);
      offer_request(8'd255, 5'd31, 6'd2);
      // last block alone, then a full-map request that clashes at the end
      offer_request(8'd255, 5'd31, 6'd1);
      offer_request(8'd1, 5'd0, 6'd32);
      // zero-length extents, one of them on an owned block
      offer_request(8'd2, 5'd0, 6'd0);
      offer_request(8'd3, 5'd31, 6'd0);
      // owner zero takes block 0, then a clash on the first block
      offer_request(8'd0, 5'd0, 6'd1);
      offer_request(8'd170, 5'd0, 6'd1);
      // extent in the middle and a request that runs into it
      offer_request(8'd85, 5'd16, 6'd4);
      offer_request(8'd128, 5'd12, 6'd10);
      // free-marker owner again, then a real owner over the same blocks
      offer_request(cba_pkg::FREE_MARK, 5'd20, 6'd4);
      offer_request(8'd9, 5'd20, 6'd4);

      // random phases: sender light / receiver heavy, swapped, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 27;
               take_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               take_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
               hold_wanted   = 1'b1;
            end
         endcase
         repeat (RANDOM_PER_PHASE) offer_random();
      end
      req_tvalid <= 1'b0;

      while (alloc_board.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Requests checked: %0d granted, %0d out of range, %0d occupied, %0d dir full",
               alloc_board.code_seen[cba_pkg::RSP_GRANTED],
               alloc_board.code_seen[cba_pkg::RSP_RANGE],
               alloc_board.code_seen[cba_pkg::RSP_OCCUPIED],
               alloc_board.code_seen[cba_pkg::RSP_FULL]);
      $display("Directory slots filled: %0d of %0d; mismatches: %0d",
               alloc_board.slots_used, DIR_SLOTS, alloc_board.errors);
      if (alloc_board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
